@@ sv/cfd_pkg.sv @@
// cfd_pkg: shared types and constants of the control frame deframer
// frame layout, register indexes, queue entry and held-value structs
// no dependencies
`default_nettype none

package cfd_pkg;

  // byte positions within a frame
  localparam int unsigned POS_W   = 5;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned PAYLOAD_LEN = 13;
  localparam logic [POS_W-1:0] POS_PAYLOAD = 5'd3;
  localparam logic [POS_W-1:0] POS_CHECK   = 5'd16;
  localparam logic [POS_W-1:0] POS_IDLE    = 5'd17;

  localparam int unsigned FAILSAFE_BIT = 1;

  // configuration register reset values
  localparam logic [15:0] RST_FAILSAFE_THR = 16'd1500;
  localparam logic [15:0] RST_AUX_OVERRIDE = 16'd1900;
  localparam logic [15:0] RST_AUX_NORMAL   = 16'd1100;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAILSAFE_THR = 2'd0,
    REG_AUX_OVERRIDE = 2'd1,
    REG_AUX_NORMAL   = 2'd2
  } reg_idx_e;

  // queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef struct packed {
    logic [15:0] failsafe_thr;
    logic [15:0] aux_override;
    logic [15:0] aux_normal;
  } cfg_t;

  // one checked frame as classified by the front
  typedef struct packed {
    logic               ok;
    logic [15:0]        roll;
    logic [15:0]        pitch;
    logic [15:0]        yaw;
    logic [15:0]        throttle;
    logic signed [31:0] height;
    logic [7:0]         flags;
  } frame_t;

  // values held between frames
  typedef struct packed {
    logic [15:0]        roll;
    logic [15:0]        pitch;
    logic [15:0]        yaw;
    logic [15:0]        throttle;
    logic [15:0]        aux;
    logic signed [31:0] height;
    logic [7:0]         flags;
  } hold_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

@@ sv/cfd_front.sv @@
// cfd_front: byte tracker of the control frame deframer
// counts frame positions, buffers payload bytes, runs the xor check
// depends on cfd_pkg
`default_nettype none

module cfd_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                byte_valid_i,
  input  wire logic [7:0]          byte_i,
  input  wire logic                start_i,
  output logic                     byte_ready_o,
  input  wire cfd_pkg::q_stat_t    q_stat_i,
  output logic                     push_o,
  output cfd_pkg::frame_t          entry_o
);

  logic [cfd_pkg::POS_W-1:0] pos_q, pos_d, pos_eff;
  logic [7:0]                xor_q, xor_d, xor_eff;
  logic [7:0]                frame_q [cfd_pkg::PAYLOAD_LEN];
  logic                      wr_en;
  logic [cfd_pkg::IDX_W-1:0] wr_idx;
  logic                      acc;

  assign byte_ready_o = !q_stat_i.full;
  assign acc          = byte_valid_i && byte_ready_o;
  assign wr_idx       = cfd_pkg::IDX_W'(pos_eff - cfd_pkg::POS_PAYLOAD);

  always_comb begin
    pos_eff = start_i ? '0 : pos_q;
    xor_eff = start_i ? '0 : xor_q;
    pos_d   = pos_q;
    xor_d   = xor_q;
    wr_en   = 1'b0;
    push_o  = 1'b0;
    if (acc) begin
      pos_d = pos_eff;
      xor_d = xor_eff;
      if (pos_eff >= cfd_pkg::POS_IDLE) begin
        // outside a frame: ignored
      end else if (pos_eff < cfd_pkg::POS_PAYLOAD) begin
        pos_d = pos_eff + 5'd1;
      end else if (pos_eff < cfd_pkg::POS_CHECK) begin
        wr_en = 1'b1;
        xor_d = xor_eff ^ byte_i;
        pos_d = pos_eff + 5'd1;
      end else begin
        push_o = 1'b1;
        pos_d  = cfd_pkg::POS_IDLE;
      end
    end
  end

  // check byte compared against the running xor of bytes 3 to 15
  always_comb begin
    entry_o.ok       = (xor_q == byte_i);
    entry_o.roll     = {frame_q[0], frame_q[1]};
    entry_o.pitch    = {frame_q[2], frame_q[3]};
    entry_o.yaw      = {frame_q[4], frame_q[5]};
    entry_o.throttle = {frame_q[6], frame_q[7]};
    entry_o.height   = {frame_q[11], frame_q[10], frame_q[9], frame_q[8]};
    entry_o.flags    = frame_q[12];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= cfd_pkg::POS_IDLE;
      xor_q <= '0;
    end else begin
      pos_q <= pos_d;
      xor_q <= xor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_q[wr_idx] <= byte_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/cfd_fifo.sv @@
// cfd_fifo: short queue of checked frames between front and back
// holds cfd_pkg::QDEPTH entries
// depends on cfd_pkg
`default_nettype none

module cfd_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire cfd_pkg::frame_t     entry_i,
  input  wire logic                pop_i,
  output cfd_pkg::frame_t          entry_o,
  output cfd_pkg::q_stat_t         stat_o
);

  cfd_pkg::frame_t            mem_q [cfd_pkg::QDEPTH];
  logic [cfd_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [cfd_pkg::QCNT_W-1:0] cnt_q, cnt_d;

  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.full  = (cnt_q == cfd_pkg::QCNT_W'(cfd_pkg::QDEPTH));
  assign entry_o      = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/cfd_back.sv @@
// cfd_back: result stage of the control frame deframer
// updates the held command values and drives the output register
// depends on cfd_pkg
`default_nettype none

module cfd_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cfd_pkg::frame_t     entry_i,
  input  wire logic                q_valid_i,
  input  wire cfd_pkg::cfg_t       cfg_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     out_ok_o,
  output cfd_pkg::hold_t           hold_o
);

  logic           valid_q, valid_d;
  logic           ok_q, ok_d;
  cfd_pkg::hold_t hold_q, hold_d;

  // the held values double as the output payload: they only move on a pop
  assign pop_o       = q_valid_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_ok_o    = ok_q;
  assign hold_o      = hold_q;

  always_comb begin
    valid_d = valid_q;
    ok_d    = ok_q;
    hold_d  = hold_q;
    if (pop_o) begin
      valid_d = 1'b1;
      ok_d    = entry_i.ok;
      if (entry_i.ok) begin
        hold_d.roll   = entry_i.roll;
        hold_d.pitch  = entry_i.pitch;
        hold_d.yaw    = entry_i.yaw;
        hold_d.height = entry_i.height;
        hold_d.flags  = entry_i.flags;
        if (entry_i.flags[cfd_pkg::FAILSAFE_BIT]) begin
          hold_d.throttle = cfg_i.failsafe_thr;
          hold_d.aux      = cfg_i.aux_override;
        end else begin
          hold_d.throttle = entry_i.throttle;
          hold_d.aux      = cfg_i.aux_normal;
        end
      end
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ok_q    <= 1'b0;
      hold_q  <= '0;
    end else begin
      valid_q <= valid_d;
      ok_q    <= ok_d;
      hold_q  <= hold_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/control_frame_deframer.sv @@
// control_frame_deframer: top level, 17-byte remote-control frame decoder
// instantiates cfd_front, cfd_fifo and cfd_back; depends on cfd_pkg
//
// usage:
//   s_axis carries one frame byte per word in tdata, tuser marks byte 0 of
//   a frame. bytes 3 to 15 are buffered and xor-checked against byte 16.
//   m_axis gives one word per frame, at its check byte: tuser says whether
//   the check matched, tdata carries the held commands (updated on a match,
//   unchanged otherwise). a start in mid-frame drops the partial frame;
//   bytes outside a frame are ignored.
//   config writes (cfg_we_i, cfg_idx_i, cfg_data_i) set failsafe throttle,
//   aux override and aux normal; they are meant for idle periods.
// throughput: one byte per cycle while the queue is not full. the front counts
//   positions, a two-entry queue holds checked frames, the back updates the held values.
// result path: the check byte writes its frame into the queue, and the back moves
//   it into the output register when that register is empty or being read.
// reset: position idle, held values zero, config back to 1500/1900/1100.
// stall: while m_axis is stalled the queue absorbs two frames beside the one
//   in the output register, then s_axis_tready drops until the word is taken.
`default_nettype none

module control_frame_deframer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,  // data_byte
  input  wire logic                         s_axis_tuser,  // frame_start
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // roll_cmd, pitch_cmd, yaw_cmd, throttle_cmd, aux_cmd, height_target, frame_flags
  output logic [119:0]                      m_axis_tdata,
  output logic                              m_axis_tuser,  // frame_ok
  input  wire logic                         cfg_we_i,
  input  wire logic [cfd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [15:0]                  cfg_data_i
);

  cfd_pkg::cfg_t    cfg_q;
  cfd_pkg::q_stat_t q_stat;
  cfd_pkg::frame_t  push_entry, q_entry;
  cfd_pkg::hold_t   hold;
  logic             fifo_push, fifo_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.failsafe_thr <= cfd_pkg::RST_FAILSAFE_THR;
      cfg_q.aux_override <= cfd_pkg::RST_AUX_OVERRIDE;
      cfg_q.aux_normal   <= cfd_pkg::RST_AUX_NORMAL;
    end else if (cfg_we_i) begin
      case (cfd_pkg::reg_idx_e'(cfg_idx_i))
        cfd_pkg::REG_FAILSAFE_THR: cfg_q.failsafe_thr <= cfg_data_i;
        cfd_pkg::REG_AUX_OVERRIDE: cfg_q.aux_override <= cfg_data_i;
        cfd_pkg::REG_AUX_NORMAL:   cfg_q.aux_normal   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_i       (s_axis_tdata),
    .start_i      (s_axis_tuser),
    .byte_ready_o (s_axis_tready),
    .q_stat_i     (q_stat),
    .push_o       (fifo_push),
    .entry_o      (push_entry)
  );

  cfd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .entry_i (push_entry),
    .pop_i   (fifo_pop),
    .entry_o (q_entry),
    .stat_o  (q_stat)
  );

  cfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (q_entry),
    .q_valid_i   (q_stat.valid),
    .cfg_i       (cfg_q),
    .pop_o       (fifo_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_ok_o    (m_axis_tuser),
    .hold_o      (hold)
  );

  assign m_axis_tdata = {hold.flags, hold.height, hold.aux, hold.throttle,
                         hold.yaw, hold.pitch, hold.roll};

  // queue never written while full
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> !q_stat.full)
    else $error("frame pushed into full queue");

  // a failed check leaves the held values untouched
  a_fail_keeps_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_pop && !q_entry.ok) |=> $stable(m_axis_tdata))
    else $error("held values changed on failed check");

  // no result appears without a queued frame
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid && !q_stat.valid) |=> !m_axis_tvalid)
    else $error("result without a queued frame");

  // a result is flagged ok only when it came from a matching frame
  a_ok_from_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |=> (m_axis_tuser == $past(q_entry.ok)))
    else $error("frame_ok does not follow the queued frame");

endmodule

`default_nettype wire

@@ tb/sv/control_frame_deframer_test.sv @@
// control_frame_deframer_test: self-checking testbench of the control frame deframer
// streams frame bytes with random gaps and stalls, predicts each result word in a scoreboard
// depends on cfd_pkg and control_frame_deframer
`timescale 1ns / 100ps

module control_frame_deframer_test;
  import cfd_pkg::*;

  localparam int unsigned FRAME_LEN   = 17;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // predicts the held command values and checks every result word
  class frame_scoreboard;
    typedef struct {
      logic  ok;
      hold_t vals;
    } frame_result_t;

    logic [15:0]      failsafe_thr;
    logic [15:0]      aux_override;
    logic [15:0]      aux_normal;
    logic [POS_W-1:0] byte_pos;
    logic [7:0]       running_xor;
    logic [7:0]       payload [PAYLOAD_LEN];
    hold_t            held;
    frame_result_t    expected_frames [$];
    int unsigned      errors;

    function new();
      failsafe_thr = RST_FAILSAFE_THR;
      aux_override = RST_AUX_OVERRIDE;
      aux_normal   = RST_AUX_NORMAL;
      byte_pos     = POS_IDLE;
      running_xor  = '0;
      held         = '0;
      errors       = 0;
      foreach (payload[i]) payload[i] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
      case (idx)
        REG_FAILSAFE_THR: failsafe_thr = value;
        REG_AUX_OVERRIDE: aux_override = value;
        REG_AUX_NORMAL:   aux_normal = value;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_frames.size();
    endfunction

    // one accepted byte: advances the frame position, may yield one result
    function void take_byte(logic [7:0] b, logic start);
      frame_result_t res;
      if (start) begin
        byte_pos    = '0;
        running_xor = '0;
      end
      if (byte_pos >= POS_IDLE) return;
      if (byte_pos < POS_PAYLOAD) begin
        byte_pos++;
        return;
      end
      if (byte_pos < POS_CHECK) begin
        payload[byte_pos - POS_PAYLOAD] = b;
        running_xor ^= b;
        byte_pos++;
        return;
      end
      res.ok = (running_xor == b);
      if (res.ok) begin
        held.roll   = {payload[0], payload[1]};
        held.pitch  = {payload[2], payload[3]};
        held.yaw    = {payload[4], payload[5]};
        held.height = {payload[11], payload[10], payload[9], payload[8]};
        held.flags  = payload[12];
        if (held.flags[FAILSAFE_BIT]) begin
          held.throttle = failsafe_thr;
          held.aux      = aux_override;
        end else begin
          held.throttle = {payload[6], payload[7]};
          held.aux      = aux_normal;
        end
      end
      res.vals = held;
      byte_pos = POS_IDLE;
      expected_frames.push_back(res);
    endfunction

    task report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(input logic ok, input logic [119:0] d);
      frame_result_t e;
      if (expected_frames.size() == 0) begin
        report_mismatch("result word with no frame pending");
        return;
      end
      e = expected_frames.pop_front();
      if (ok !== e.ok)
        report_mismatch($sformatf("frame_ok %b, expected %b", ok, e.ok));
      if (d[15:0] !== e.vals.roll)
        report_mismatch($sformatf("roll %h, expected %h", d[15:0], e.vals.roll));
      if (d[31:16] !== e.vals.pitch)
        report_mismatch($sformatf("pitch %h, expected %h", d[31:16], e.vals.pitch));
      if (d[47:32] !== e.vals.yaw)
        report_mismatch($sformatf("yaw %h, expected %h", d[47:32], e.vals.yaw));
      if (d[63:48] !== e.vals.throttle)
        report_mismatch($sformatf("throttle %h, expected %h", d[63:48], e.vals.throttle));
      if (d[79:64] !== e.vals.aux)
        report_mismatch($sformatf("aux %h, expected %h", d[79:64], e.vals.aux));
      if (d[111:80] !== e.vals.height)
        report_mismatch($sformatf("height %h, expected %h", d[111:80], e.vals.height));
      if (d[119:112] !== e.vals.flags)
        report_mismatch($sformatf("flags %h, expected %h", d[119:112], e.vals.flags));
    endtask
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [119:0]         m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [15:0]          cfg_data_i    = '0;

  frame_scoreboard sb = new();
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned rx_hold     = 0;
  int unsigned cycles      = 0;

  control_frame_deframer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata);
  end

  // receiver: random stalls, or a long hold-off counted down here
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold != 0) begin
        m_axis_tready <= 1'b0;
        rx_hold--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // all driving tasks start and end at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic start);
    // each cycle the sender idles with the set chance
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= start;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_byte(b, start);
    @(negedge clk_i);
  endtask

  // sends the first len bytes of a frame; a bad check flips bits of byte 16
  task automatic send_frame(input int unsigned len, input bit bad_check);
    logic [7:0] body [PAYLOAD_LEN];
    logic [7:0] chk;
    chk = '0;
    foreach (body[i]) begin
      body[i] = pick_byte();
      chk ^= body[i];
    end
    if (bad_check) chk ^= 8'($urandom_range(1, 255));
    for (int i = 0; i < len; i++) begin
      if (i < POS_PAYLOAD) send_byte(pick_byte(), i == 0);
      else if (i < POS_CHECK) send_byte(body[i - POS_PAYLOAD], 1'b0);
      else send_byte(chk, 1'b0);
    end
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n) send_byte(pick_byte(), 1'b0);
  endtask

  // holds the input off until every pending result word is out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_regs(input logic [15:0] thr, input logic [15:0] ovr,
                            input logic [15:0] nrm);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [15:0]          val [4];
    idx = '{REG_FAILSAFE_THR, REG_AUX_OVERRIDE, REG_AUX_NORMAL, REG_UNUSED};
    val = '{thr, ovr, nrm, 16'($urandom)};
    drain();
    // let the last frame settle through queue and output register
    repeat (4) @(negedge clk_i);
    foreach (idx[i]) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i];
      sb.set_reg(idx[i], val[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // mostly well-formed frames, some with bad checks, cut short or noise
  task automatic run_frames(input int unsigned n_items, input int hold_at,
                            input int pause_at);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    int unsigned n_noise;
    int          seq;
    sent = 0;
    seq  = 0;
    while (sent < n_items) begin
      if (seq == hold_at) rx_hold = 400;
      if (seq == pause_at) drain();
      pick = (seq == 0) ? 0 : $urandom_range(99);
      if (pick < 60) begin
        send_frame(FRAME_LEN, 1'b0);
        sent += FRAME_LEN;
        n_noise = $urandom_range(0, 2);
        send_noise(n_noise);
        sent += n_noise;
      end else if (pick < 75) begin
        send_frame(FRAME_LEN, 1'b1);
        sent += FRAME_LEN;
      end else if (pick < 90) begin
        len = $urandom_range(1, FRAME_LEN - 1);
        send_frame(len, 1'b0);
        sent += len;
      end else begin
        n_noise = $urandom_range(1, 3);
        send_noise(n_noise);
        sent += n_noise;
      end
      seq++;
    end
  endtask

  initial begin
    logic [7:0] ones [PAYLOAD_LEN];
    foreach (ones[i]) ones[i] = 8'hff;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    tx_idle_pct = 36;
    rx_idle_pct = 59;
    // byte before any start, a frame cut short by a new start,
    // an all-ones frame with failsafe set, then bytes past the check
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    foreach (ones[i]) send_byte(ones[i], 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);

    write_regs(16'hffff, 16'hffff, 16'hffff);
    run_frames(345, -1, -1);

    tx_idle_pct = 59;
    rx_idle_pct = 36;
    write_regs(16'h0000, 16'h0000, 16'h0000);
    run_frames(345, -1, 20);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_regs(16'($urandom), 16'($urandom), 16'($urandom));
    run_frames(345, 10, -1);

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d result words never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
